// ===== design/dpllpi_pkg.sv =====
// Shared types, widths and constants of the DPLL loop filter and NCO block.
package dpllpi_pkg;

  // Field and datapath widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PHASE_W    = 32;   // NCO phase width, 16 to 48
  localparam int unsigned EXT_W      = PHASE_W + DATA_W;
  localparam int unsigned NCO_FRAC_W = 48;   // fraction bits of freq * dt in turns
  localparam int unsigned LIMIT_W    = 31;

  // Serial multiplier geometry
  localparam int unsigned MCAND_W  = 2 * DATA_W;
  localparam int unsigned MPLIER_W = DATA_W;
  localparam int unsigned PROD_W   = MCAND_W + MPLIER_W;
  localparam int unsigned CNT_W    = $clog2(MPLIER_W);

  // Gain term: (|g| * |e| * 2pi_q29 + 2^60) >> 61
  localparam int unsigned ROUND_SH = 61;
  localparam int unsigned RND_W    = PROD_W - ROUND_SH + 1;
  localparam int unsigned ACC_W    = RND_W + 2;
  localparam int unsigned FSUM_W   = ACC_W + 1;

  localparam logic [DATA_W-1:0]         TWO_PI_Q29 = 32'd3373259426;
  localparam logic [LIMIT_W-1:0]        LIMIT_RST  = 31'd65536000;
  localparam logic signed [DATA_W-1:0]  SWORD_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0]  SWORD_MIN  = 32'sh8000_0000;

  typedef logic [DATA_W-1:0]         word_t;
  typedef logic signed [DATA_W-1:0]  sword_t;
  typedef logic [PHASE_W-1:0]        phase_t;
  typedef logic [EXT_W-1:0]          ext_t;
  typedef logic [MCAND_W-1:0]        mcand_t;
  typedef logic [MPLIER_W-1:0]       mplier_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [RND_W-1:0]          rnd_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [FSUM_W-1:0]  fsum_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 2'd0,
    CFG_INTEG_GAIN  = 2'd1,
    CFG_INTEG_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] meas_freq;
    logic signed [DATA_W-1:0] meas_phase;
    logic [DATA_W-1:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] corr_freq;
    logic signed [DATA_W-1:0] phase_error;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic [LIMIT_W-1:0]       integ_limit;
  } cfg_t;

  typedef struct packed {
    logic    start;
    mcand_t  mcand;
    mplier_t mplier;
  } mul_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    prod_t prod;
  } mul_rsp_t;

endpackage

// ===== design/dpllpi_smul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module dpllpi_smul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dpllpi_pkg::mul_req_t req_i,
  output dpllpi_pkg::mul_rsp_t rsp_o
);

  dpllpi_pkg::mcand_t                  hi_q, hi_d;
  dpllpi_pkg::mcand_t                  mcand_q, mcand_d;
  dpllpi_pkg::mplier_t                 lo_q, lo_d;
  logic [dpllpi_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [dpllpi_pkg::MCAND_W:0]        add_sum;

  // Add the multiplicand into the upper half when the current bit is set
  assign add_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  // Load on start, then shift the partial product right once per bit
  always_comb begin
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      hi_d    = '0;
      lo_d    = req_i.mplier;
      mcand_d = req_i.mcand;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      hi_d  = add_sum[dpllpi_pkg::MCAND_W:1];
      lo_d  = {add_sum[0], lo_q[dpllpi_pkg::MPLIER_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dpllpi_pkg::CNT_W'(dpllpi_pkg::MPLIER_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};

  // A new product is never requested while one is in progress
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier started while busy");

  // Completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held longer than one cycle");

endmodule

// ===== design/dpllpi_core.sv =====
// Loop sequencer: phase error, PI filter with clamped integral, NCO phase update.
module dpllpi_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dpllpi_pkg::cfg_t      cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dpllpi_pkg::in_item_t  in_data_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output dpllpi_pkg::out_item_t res_data_o,
  output dpllpi_pkg::mul_req_t  mul_req_o,
  input  dpllpi_pkg::mul_rsp_t  mul_rsp_i
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_M_ERR = 9'b000000010,
    ST_M_KI  = 9'b000000100,
    ST_INTEG = 9'b000001000,
    ST_M_KP  = 9'b000010000,
    ST_SUM   = 9'b000100000,
    ST_SAT   = 9'b001000000,
    ST_M_NCO = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  logic                   go_q, go_d;
  dpllpi_pkg::in_item_t   item_q, item_d;
  dpllpi_pkg::word_t      err_q, err_d;
  dpllpi_pkg::mcand_t     m1_q, m1_d;
  dpllpi_pkg::rnd_t       r_q, r_d;
  logic                   neg_q, neg_d;
  dpllpi_pkg::sword_t     integ_q, integ_d;
  dpllpi_pkg::acc_t       tsum_q, tsum_d;
  dpllpi_pkg::sword_t     freq_q, freq_d;
  dpllpi_pkg::phase_t     nco_q, nco_d;

  dpllpi_pkg::ext_t       mp_ext, err_ext;
  dpllpi_pkg::phase_t     mp_w, err_w, adv;
  dpllpi_pkg::word_t      err32, e_abs, ki_abs, kp_abs;
  logic [dpllpi_pkg::RND_W:0] rnd_sum;
  dpllpi_pkg::rnd_t       rnd;
  dpllpi_pkg::acc_t       integ_ext, r_ext, lim_ext, pi_sum, clamp;
  dpllpi_pkg::fsum_t      fsum;
  dpllpi_pkg::sword_t     sat;
  dpllpi_pkg::mcand_t     low_prod;

  // Align the measured phase to the NCO width and wrap the difference
  assign mp_ext  = {in_data_i.meas_phase, {dpllpi_pkg::PHASE_W{1'b0}}};
  assign mp_w    = dpllpi_pkg::phase_t'(mp_ext >> dpllpi_pkg::DATA_W);
  assign err_w   = mp_w - nco_q;
  assign err_ext = {err_w, {dpllpi_pkg::DATA_W{1'b0}}} >> dpllpi_pkg::PHASE_W;
  assign err32   = err_ext[dpllpi_pkg::DATA_W-1:0];

  // Magnitudes for the unsigned serial products
  assign e_abs  = err_q[dpllpi_pkg::DATA_W-1] ? (~err_q + 1'b1) : err_q;
  assign ki_abs = cfg_i.integ_gain[dpllpi_pkg::DATA_W-1] ?
                  (~dpllpi_pkg::word_t'(cfg_i.integ_gain) + 1'b1) :
                  dpllpi_pkg::word_t'(cfg_i.integ_gain);
  assign kp_abs = cfg_i.prop_gain[dpllpi_pkg::DATA_W-1] ?
                  (~dpllpi_pkg::word_t'(cfg_i.prop_gain) + 1'b1) :
                  dpllpi_pkg::word_t'(cfg_i.prop_gain);

  // Round the scaled product to Q16.16, half away from zero on the magnitude
  assign rnd_sum = {1'b0, mul_rsp_i.prod[dpllpi_pkg::PROD_W-1:dpllpi_pkg::ROUND_SH-1]}
                 + {{dpllpi_pkg::RND_W{1'b0}}, 1'b1};
  assign rnd     = rnd_sum[dpllpi_pkg::RND_W:1];

  // Integral plus signed gain term, shared by the clamp and the output sum
  assign integ_ext = dpllpi_pkg::acc_t'(integ_q);
  assign r_ext     = dpllpi_pkg::acc_t'(r_q);
  assign lim_ext   = dpllpi_pkg::acc_t'(cfg_i.integ_limit);
  assign pi_sum    = neg_q ? (integ_ext - r_ext) : (integ_ext + r_ext);

  // Clamp the integral to the symmetric limit
  always_comb begin
    priority if (pi_sum > lim_ext) begin
      clamp = lim_ext;
    end else if (pi_sum < -lim_ext) begin
      clamp = -lim_ext;
    end else begin
      clamp = pi_sum;
    end
  end

  // Saturate the corrected frequency to 32 bits
  assign fsum = dpllpi_pkg::fsum_t'(item_q.meas_freq) + dpllpi_pkg::fsum_t'(tsum_q);
  always_comb begin
    priority if (fsum > dpllpi_pkg::fsum_t'(dpllpi_pkg::SWORD_MAX)) begin
      sat = dpllpi_pkg::SWORD_MAX;
    end else if (fsum < dpllpi_pkg::fsum_t'(dpllpi_pkg::SWORD_MIN)) begin
      sat = dpllpi_pkg::SWORD_MIN;
    end else begin
      sat = dpllpi_pkg::sword_t'(fsum);
    end
  end

  // Phase advance: keep the turn fraction bits of freq * dt
  assign low_prod = mul_rsp_i.prod[dpllpi_pkg::MCAND_W-1:0];
  assign adv      = dpllpi_pkg::phase_t'(low_prod >>
                    (dpllpi_pkg::NCO_FRAC_W - dpllpi_pkg::PHASE_W));

  // Select multiplier operands by step
  always_comb begin
    mul_req_o.start  = go_q;
    mul_req_o.mcand  = '0;
    mul_req_o.mplier = '0;
    unique case (state_q)
      ST_M_ERR: begin
        mul_req_o.mcand  = dpllpi_pkg::mcand_t'(e_abs);
        mul_req_o.mplier = dpllpi_pkg::TWO_PI_Q29;
      end
      ST_M_KI: begin
        mul_req_o.mcand  = m1_q;
        mul_req_o.mplier = ki_abs;
      end
      ST_M_KP: begin
        mul_req_o.mcand  = m1_q;
        mul_req_o.mplier = kp_abs;
      end
      ST_M_NCO: begin
        mul_req_o.mcand  = dpllpi_pkg::mcand_t'(freq_q);
        mul_req_o.mplier = item_q.time_step;
      end
      default: begin
        mul_req_o.mcand  = '0;
        mul_req_o.mplier = '0;
      end
    endcase
  end

  // Sequence one update through the shared multiplier
  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    item_d  = item_q;
    err_d   = err_q;
    m1_d    = m1_q;
    r_d     = r_q;
    neg_d   = neg_q;
    integ_d = integ_q;
    tsum_d  = tsum_q;
    freq_d  = freq_q;
    nco_d   = nco_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          err_d   = err32;
          state_d = ST_M_ERR;
          go_d    = 1'b1;
        end
      end
      ST_M_ERR: begin
        if (mul_rsp_i.done) begin
          m1_d    = low_prod;
          state_d = ST_M_KI;
          go_d    = 1'b1;
        end
      end
      ST_M_KI: begin
        if (mul_rsp_i.done) begin
          r_d     = rnd;
          neg_d   = cfg_i.integ_gain[dpllpi_pkg::DATA_W-1] ^ err_q[dpllpi_pkg::DATA_W-1];
          state_d = ST_INTEG;
        end
      end
      ST_INTEG: begin
        integ_d = dpllpi_pkg::sword_t'(clamp);
        state_d = ST_M_KP;
        go_d    = 1'b1;
      end
      ST_M_KP: begin
        if (mul_rsp_i.done) begin
          r_d     = rnd;
          neg_d   = cfg_i.prop_gain[dpllpi_pkg::DATA_W-1] ^ err_q[dpllpi_pkg::DATA_W-1];
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        tsum_d  = pi_sum;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        freq_d  = sat;
        state_d = ST_M_NCO;
        go_d    = 1'b1;
      end
      ST_M_NCO: begin
        if (mul_rsp_i.done) begin
          nco_d   = nco_q + adv;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      integ_q <= '0;
      nco_q   <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      integ_q <= integ_d;
      nco_q   <= nco_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    err_q  <= err_d;
    m1_q   <= m1_d;
    r_q    <= r_d;
    neg_q  <= neg_d;
    tsum_q <= tsum_d;
    freq_q <= freq_d;
  end

  assign in_ready_o              = (state_q == ST_IDLE);
  assign res_valid_o             = (state_q == ST_DONE);
  assign res_data_o.corr_freq    = freq_q;
  assign res_data_o.phase_error  = err_q;

  // The multiplier is free whenever a new transaction can be taken
  a_idle_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mul_rsp_i.busy)
    else $error("multiplier busy while sequencer idle");

  // The stored integral respects the limit it was clamped against
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |->
      ((dpllpi_pkg::acc_t'(integ_q) <= dpllpi_pkg::acc_t'($past(cfg_i.integ_limit))) &&
       (dpllpi_pkg::acc_t'(integ_q) >= -dpllpi_pkg::acc_t'($past(cfg_i.integ_limit)))))
    else $error("integral outside its limit");

  // The phase error product is launched on entry to its step
  a_mul_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && in_valid_i) |=> (go_q && (state_q == ST_M_ERR)))
    else $error("phase error product not launched");

endmodule

// ===== design/dpll_pi_loop_nco_unit.sv =====
// Top level of the DPLL: configuration registers, loop sequencer, result register.
//
// Usage:
//   Configuration: write cfg_data_i to register cfg_idx_i (0 proportional
//   gain, 1 integral gain, 2 integral limit) with cfg_valid_i; cfg_ready_o
//   is always high. Unknown indexes are dropped. Write only while idle.
//   Input: one transaction on in_valid_i/in_ready_o per loop update
//   (measured frequency, measured phase, time step). Output: one transaction
//   per update on out_valid_o/out_ready_i (corrected frequency, phase error).
//   Timing: every product goes through one shared bit-serial multiplier,
//   one bit of its 32-bit multiplier operand per cycle. Each update runs
//   four products in turn (phase error, integral gain, proportional gain,
//   NCO advance), and a new input is taken only after the previous result
//   has been handed to the output register.
//   Stalls: the result waits in an output register; the next update is
//   accepted and computed meanwhile, and holds at its end until that
//   register frees up.
//   Reset: the NCO phase and integral clear to zero, gains to zero and the
//   limit to 1000 Hz; no transaction is pending.
module dpll_pi_loop_nco_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpllpi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpllpi_pkg::DATA_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dpllpi_pkg::in_item_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dpllpi_pkg::out_item_t               out_data_o
);

  dpllpi_pkg::cfg_t      cfg_q, cfg_d;
  logic                  out_valid_q, out_valid_d;
  dpllpi_pkg::out_item_t out_data_q, out_data_d;
  logic                  res_valid, res_ready;
  dpllpi_pkg::out_item_t res_data;
  dpllpi_pkg::mul_req_t  mul_req;
  dpllpi_pkg::mul_rsp_t  mul_rsp;

  assign cfg_ready_o = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        dpllpi_pkg::CFG_PROP_GAIN:   cfg_d.prop_gain   = cfg_data_i;
        dpllpi_pkg::CFG_INTEG_GAIN:  cfg_d.integ_gain  = cfg_data_i;
        dpllpi_pkg::CFG_INTEG_LIMIT: cfg_d.integ_limit =
                                       cfg_data_i[dpllpi_pkg::LIMIT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= '0;
      cfg_q.integ_gain  <= '0;
      cfg_q.integ_limit <= dpllpi_pkg::LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Hold the finished result until the receiver takes it
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  dpllpi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

  dpllpi_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the DPLL loop filter and NCO, directed and random loop updates.
module testbench;

  localparam int PW = dpllpi_pkg::PHASE_W;
  localparam logic [63:0] PHASE_MASK = (64'd1 << PW) - 64'd1;
  localparam logic [dpllpi_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int HALF_PERIOD = 2;
  localparam int IDLE_PCT = 30;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 150;
  localparam int RAND_PHASES = 6;
  localparam int RAND_ITEMS = 142;
  localparam int REPORT_MAX = 10;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [dpllpi_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  dpllpi_pkg::word_t     cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  dpllpi_pkg::in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  dpllpi_pkg::out_item_t out_data_o;

  // Pending updates for the driver and results still owed by the block
  dpllpi_pkg::in_item_t  pending_meas[$];
  dpllpi_pkg::out_item_t freq_err_q[$];

  // Loop state and registers as the block should hold them
  logic [63:0] nco_turns = '0;
  longint      integ_hz = 0;
  longint      gain_p = 0;
  longint      gain_i = 0;
  longint      integ_bound = longint'(dpllpi_pkg::LIMIT_RST);

  logic        in_hs = 1'b0;
  logic        calm = 1'b0;
  int          hold_go = 0;
  int          hold_taken = 0;
  int          hold_left = 0;
  int unsigned err_cnt = 0;

  dpll_pi_loop_nco_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Generate the clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Frequency correction of one gain: gain * err * 2pi / 2^32, rounded half away from zero
  function automatic longint corr_hz(input longint gain, input longint err);
    longint       prod;
    logic [127:0] mag;
    logic [127:0] scaled;
    prod = gain * err;
    mag = (prod < 0) ? 128'(-prod) : 128'(prod);
    scaled = (mag * 128'(dpllpi_pkg::TWO_PI_Q29) +
              (128'd1 << (dpllpi_pkg::ROUND_SH - 1))) >> dpllpi_pkg::ROUND_SH;
    return (prod < 0) ? -longint'(scaled[63:0]) : longint'(scaled[63:0]);
  endfunction

  // Run one loop update on the local state and return the result it owes
  function automatic dpllpi_pkg::out_item_t loop_update(input dpllpi_pkg::in_item_t m);
    logic [63:0]           meas_w;
    logic [63:0]           err_w;
    logic [63:0]           advance;
    dpllpi_pkg::word_t     err_word;
    longint                err_s;
    longint                integ_sum;
    longint                freq_sum;
    dpllpi_pkg::out_item_t r;
    if (PW >= 32) begin
      meas_w = {32'd0, m.meas_phase} << (PW - 32);
    end else begin
      meas_w = {32'd0, m.meas_phase} >> (32 - PW);
    end
    err_w = (meas_w - nco_turns) & PHASE_MASK;
    if (PW >= 32) begin
      err_word = dpllpi_pkg::word_t'(err_w >> (PW - 32));
    end else begin
      err_word = dpllpi_pkg::word_t'(err_w << (32 - PW));
    end
    err_s = longint'($signed(err_word));

    // Integrate and clamp to the symmetric bound
    integ_sum = integ_hz + corr_hz(gain_i, err_s);
    if (integ_sum > integ_bound) integ_sum = integ_bound;
    if (integ_sum < -integ_bound) integ_sum = -integ_bound;
    integ_hz = integ_sum;

    // Correct the frequency and saturate to one signed word
    freq_sum = longint'($signed(m.meas_freq)) + corr_hz(gain_p, err_s) + integ_hz;
    if (freq_sum > longint'(dpllpi_pkg::SWORD_MAX)) freq_sum = longint'(dpllpi_pkg::SWORD_MAX);
    if (freq_sum < longint'(dpllpi_pkg::SWORD_MIN)) freq_sum = longint'(dpllpi_pkg::SWORD_MIN);

    // Advance the NCO by freq * dt, a Q16.48 turn count, floored to the phase width
    advance = 64'(freq_sum) * {32'd0, m.time_step};
    advance = advance >> (dpllpi_pkg::NCO_FRAC_W - PW);
    nco_turns = (nco_turns + advance) & PHASE_MASK;

    r.corr_freq = dpllpi_pkg::word_t'(freq_sum);
    r.phase_error = err_word;
    return r;
  endfunction

  function automatic dpllpi_pkg::word_t nco_word();
    return (PW >= 32) ? dpllpi_pkg::word_t'(nco_turns >> (PW - 32)) :
                        dpllpi_pkg::word_t'(nco_turns << (32 - PW));
  endfunction

  function automatic void note_mismatch(input string what, input dpllpi_pkg::word_t want,
                                        input dpllpi_pkg::word_t got);
    if (err_cnt < REPORT_MAX) begin
      $display("%0t ns %s: expected %h, got %h", $time, what, want, got);
    end
    err_cnt++;
  endfunction

  function automatic dpllpi_pkg::word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX);
      3: return dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN);
      4, 5: return dpllpi_pkg::word_t'($urandom_range(2047)) - 32'd1024;
      default: return dpllpi_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic dpllpi_pkg::word_t pick_gain();
    dpllpi_pkg::word_t g;
    case ($urandom_range(3))
      0, 1: g = $urandom_range(1 << 20);
      2: g = $urandom_range(1 << 27);
      default: g = $urandom;
    endcase
    if ($urandom_range(1)) g = -g;
    return g;
  endfunction

  function automatic dpllpi_pkg::word_t pick_limit();
    case ($urandom_range(3))
      0: return dpllpi_pkg::word_t'(dpllpi_pkg::LIMIT_RST);
      1: return dpllpi_pkg::word_t'($urandom_range(1 << 28));
      default: return dpllpi_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic queue_meas(input dpllpi_pkg::word_t freq, input dpllpi_pkg::word_t phase,
                            input dpllpi_pkg::word_t dt);
    dpllpi_pkg::in_item_t item;
    item.meas_freq = freq;
    item.meas_phase = phase;
    item.time_step = dt;
    pending_meas.push_back(item);
  endtask

  // Write one register and mirror it once the transaction completes
  task automatic write_reg(input logic [dpllpi_pkg::CFG_IDX_W-1:0] idx,
                           input dpllpi_pkg::word_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dpllpi_pkg::CFG_PROP_GAIN: gain_p = longint'($signed(data));
      dpllpi_pkg::CFG_INTEG_GAIN: gain_i = longint'($signed(data));
      dpllpi_pkg::CFG_INTEG_LIMIT: integ_bound = longint'(data[dpllpi_pkg::LIMIT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic cfg_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every update is taken and every result has come back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_meas.size() != 0 || in_valid_i || freq_err_q.size() != 0);
  endtask

  // Mostly a clean reference tone with small jitter, the rest arbitrary words
  task automatic fill_random(input int count);
    dpllpi_pkg::sword_t src_freq;
    dpllpi_pkg::word_t  src_phase;
    dpllpi_pkg::word_t  dt;
    src_freq = dpllpi_pkg::sword_t'($urandom_range(1 << 26));
    if ($urandom_range(1)) src_freq = -src_freq;
    src_phase = $urandom;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 70) begin
        dt = $urandom_range(1 << 24, 1 << 16);
        src_phase += dpllpi_pkg::word_t'((64'(src_freq) * 64'(dt)) >> 16);
        queue_meas(dpllpi_pkg::word_t'(src_freq) + $urandom_range(255) - 32'd128,
                   src_phase + $urandom_range(4095) - 32'd2048, dt);
      end else begin
        queue_meas(pick_word(), pick_word(), pick_word());
      end
    end
  endtask

  // Drive the input channel, refilling the slot only after a transaction
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_hs)) begin
      if (pending_meas.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_meas.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive ready on the result side, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_taken != hold_go) begin
      hold_taken <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Predict the result of each accepted update
  always @(posedge clk_i) begin
    in_hs <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      freq_err_q.push_back(loop_update(in_data_i));
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    dpllpi_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (freq_err_q.size() == 0) begin
        note_mismatch("result with none pending", '0, out_data_o.corr_freq);
      end else begin
        want = freq_err_q.pop_front();
        if (out_data_o.corr_freq !== want.corr_freq) begin
          note_mismatch("corr_freq", want.corr_freq, out_data_o.corr_freq);
        end
        if (out_data_o.phase_error !== want.phase_error) begin
          note_mismatch("phase_error", want.phase_error, out_data_o.phase_error);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin : stim
    dpllpi_pkg::word_t base;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers; zero time steps hold the NCO so phase offsets are exact
    base = nco_word();
    queue_meas('0, base, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX), base + 32'h7FFF_FFFF, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN), base + 32'h8000_0000, '0);
    queue_meas($urandom, $urandom, '1);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN), $urandom, '1);
    drain();

    // Largest positive gains, widest bound; the unused index must change nothing
    write_reg(dpllpi_pkg::CFG_PROP_GAIN, dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX));
    write_reg(dpllpi_pkg::CFG_INTEG_GAIN, dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX));
    write_reg(dpllpi_pkg::CFG_INTEG_LIMIT, '1);
    write_reg(CFG_IDX_UNUSED, '0);
    cfg_idle();
    base = nco_word();
    queue_meas('0, base + 32'h8000_0000, '0);
    queue_meas('0, base + 32'h7FFF_FFFF, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX), base + 32'd1, '0);
    queue_meas('0, base + 32'hFFFF_FFFF, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX), base + 32'h4000_0000,
               32'h0001_0000);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN), $urandom, $urandom);
    drain();

    // Most negative gains and a zero bound: saturate both ways, then advance saturated
    write_reg(dpllpi_pkg::CFG_PROP_GAIN, dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN));
    write_reg(dpllpi_pkg::CFG_INTEG_GAIN, dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN));
    write_reg(dpllpi_pkg::CFG_INTEG_LIMIT, '0);
    cfg_idle();
    base = nco_word();
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX), base + 32'h8000_0000, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN), base + 32'h7FFF_FFFF, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MIN), base + 32'd1, '0);
    queue_meas(dpllpi_pkg::word_t'(dpllpi_pkg::SWORD_MAX), base + 32'h8000_0000, '1);
    queue_meas('0, $urandom, $urandom);
    drain();

    // Wind the integral up to a wide bound
    write_reg(dpllpi_pkg::CFG_PROP_GAIN, '0);
    write_reg(dpllpi_pkg::CFG_INTEG_GAIN, 32'h4000_0000);
    write_reg(dpllpi_pkg::CFG_INTEG_LIMIT, 32'h7FFF_FFFF);
    write_reg(CFG_IDX_UNUSED, '1);
    cfg_idle();
    base = nco_word();
    repeat (4) queue_meas('0, base + 32'h4000_0000, '0);
    drain();

    // Lower the bound: the next zero-error update clamps the integral back
    write_reg(dpllpi_pkg::CFG_INTEG_LIMIT, dpllpi_pkg::word_t'(dpllpi_pkg::LIMIT_RST));
    cfg_idle();
    base = nco_word();
    queue_meas('0, base, '0);
    queue_meas('0, base - 32'h4000_0000, '0);
    queue_meas($urandom, $urandom, $urandom);
    drain();

    // Random settings; one phase without idling, one with a long result stall
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(dpllpi_pkg::CFG_PROP_GAIN, pick_gain());
      write_reg(dpllpi_pkg::CFG_INTEG_GAIN, pick_gain());
      write_reg(dpllpi_pkg::CFG_INTEG_LIMIT, pick_limit());
      cfg_idle();
      calm = (ph == 1);
      fill_random(RAND_ITEMS);
      if (ph == 3) hold_go++;
      drain();
    end
    calm = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dpllpi_pkg.sv
design/dpllpi_smul.sv
design/dpllpi_core.sv
design/dpll_pi_loop_nco_unit.sv
sim/testbench.sv
